// ----- rtl/gbrc_pkg.sv -----
// Shared types, constants and coefficient tables for the green-band converter.
package gbrc_pkg;

  localparam int FRAC_BITS = 28;
  localparam int LOGF      = 24;
  localparam int RW        = 32;
  localparam int WW        = 14;
  localparam int NBANDS    = 4;
  localparam int SELW      = 2;
  localparam int NW        = 16;

  localparam longint MICRO       = 64'sd1000000;
  localparam longint LOG2_10_Q30 = 64'sd3566893132;
  localparam longint ONE         = 64'sd1 <<< FRAC_BITS;

  // Rounding terms for half-away-from-zero conversion of the coefficients.
  localparam longint HALF_MICRO = MICRO / 2;
  localparam longint B1_DEN     = MICRO * 64;
  localparam longint B1_HALF    = B1_DEN / 2;

  localparam logic [WW-1:0] PASS_LO = 14'd5530;
  localparam logic [WW-1:0] PASS_HI = 14'd5570;

  typedef enum logic [1:0] {
    ST_PASS    = 2'd0,
    ST_CONV    = 2'd1,
    ST_UNSUP   = 2'd2,
    ST_INVALID = 2'd3
  } status_t;

  // Item state carried down the pipeline beside the arithmetic.
  typedef struct packed {
    logic            pow;
    status_t         status;
    logic [RW-1:0]   res;
  } item_t;

  function automatic longint unsigned isqrt64(longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) begin
        r = t;
      end
    end
    return r;
  endfunction

  // 2^(2^-k) in Q30 via chained floor square roots.
  function automatic logic [31:0] tpow(int k);
    longint unsigned t;
    t = isqrt64(64'd1 << 61);
    for (int j = 2; j <= k; j++) begin
      t = isqrt64(t << 30);
    end
    return t[31:0];
  endfunction

  localparam longint C_CTR [NBANDS] = '{5470, 5500, 5600, 5650};
  localparam longint C_SW  [NBANDS] = '{1723, 1597, 1148, 891};
  localparam longint C_A1  [NBANDS] = '{986000, 988000, 1023000, 1039000};
  localparam longint C_B1  [NBANDS] = '{81495, 62195, -103624, -183044};
  localparam longint C_A2  [NBANDS] = '{1031000, 1014000, 979000, 971000};
  localparam longint C_B2  [NBANDS] = '{216, 128, -121, -170};

  localparam logic [WW-1:0] BAND_LO [NBANDS] = '{
    WW'(C_CTR[0] - 20), WW'(C_CTR[1] - 20), WW'(C_CTR[2] - 20), WW'(C_CTR[3] - 20)};
  localparam logic [WW-1:0] BAND_HI [NBANDS] = '{
    WW'(C_CTR[0] + 20), WW'(C_CTR[1] + 20), WW'(C_CTR[2] + 20), WW'(C_CTR[3] + 20)};

  // sw, a1 and a2 are positive in every band.
  localparam logic signed [RW-1:0] SW_Q [NBANDS] = '{
    RW'((C_SW[0] * ONE + HALF_MICRO) / MICRO), RW'((C_SW[1] * ONE + HALF_MICRO) / MICRO),
    RW'((C_SW[2] * ONE + HALF_MICRO) / MICRO), RW'((C_SW[3] * ONE + HALF_MICRO) / MICRO)};
  localparam logic signed [RW-1:0] A1_Q [NBANDS] = '{
    RW'(((C_A1[0] <<< 30) + HALF_MICRO) / MICRO),
    RW'(((C_A1[1] <<< 30) + HALF_MICRO) / MICRO),
    RW'(((C_A1[2] <<< 30) + HALF_MICRO) / MICRO),
    RW'(((C_A1[3] <<< 30) + HALF_MICRO) / MICRO)};
  localparam logic signed [RW-1:0] A2_Q [NBANDS] = '{
    RW'(((C_A2[0] <<< 30) + HALF_MICRO) / MICRO),
    RW'(((C_A2[1] <<< 30) + HALF_MICRO) / MICRO),
    RW'(((C_A2[2] <<< 30) + HALF_MICRO) / MICRO),
    RW'(((C_A2[3] <<< 30) + HALF_MICRO) / MICRO)};
  localparam logic signed [RW-1:0] B2_Q [NBANDS] = '{
    RW'(C_B2[0] >= 0 ? (C_B2[0] * ONE + HALF_MICRO) / MICRO
                     : -((-C_B2[0] * ONE + HALF_MICRO) / MICRO)),
    RW'(C_B2[1] >= 0 ? (C_B2[1] * ONE + HALF_MICRO) / MICRO
                     : -((-C_B2[1] * ONE + HALF_MICRO) / MICRO)),
    RW'(C_B2[2] >= 0 ? (C_B2[2] * ONE + HALF_MICRO) / MICRO
                     : -((-C_B2[2] * ONE + HALF_MICRO) / MICRO)),
    RW'(C_B2[3] >= 0 ? (C_B2[3] * ONE + HALF_MICRO) / MICRO
                     : -((-C_B2[3] * ONE + HALF_MICRO) / MICRO))};
  localparam logic signed [RW-1:0] B1_Q [NBANDS] = '{
    RW'(C_B1[0] >= 0 ? (C_B1[0] * LOG2_10_Q30 + B1_HALF) / B1_DEN
                     : -((-C_B1[0] * LOG2_10_Q30 + B1_HALF) / B1_DEN)),
    RW'(C_B1[1] >= 0 ? (C_B1[1] * LOG2_10_Q30 + B1_HALF) / B1_DEN
                     : -((-C_B1[1] * LOG2_10_Q30 + B1_HALF) / B1_DEN)),
    RW'(C_B1[2] >= 0 ? (C_B1[2] * LOG2_10_Q30 + B1_HALF) / B1_DEN
                     : -((-C_B1[2] * LOG2_10_Q30 + B1_HALF) / B1_DEN)),
    RW'(C_B1[3] >= 0 ? (C_B1[3] * LOG2_10_Q30 + B1_HALF) / B1_DEN
                     : -((-C_B1[3] * LOG2_10_Q30 + B1_HALF) / B1_DEN))};

endpackage

// ----- rtl/gbrc_front.sv -----
// Front stages: band decode, branch choice, linear form, log2 normalization.
module gbrc_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          in_valid,
  input  logic signed [gbrc_pkg::RW-1:0] rrs_in,
  input  logic [gbrc_pkg::WW-1:0]       wavelength_tenths,
  output logic                          valid,
  output gbrc_pkg::item_t               item,
  output logic [gbrc_pkg::SELW-1:0]     sel,
  output logic [gbrc_pkg::RW-1:0]       mant,
  output logic signed [gbrc_pkg::RW-1:0] lq
);

  // stage 1
  logic                          v1;
  logic signed [gbrc_pkg::RW-1:0] r1;
  logic                          pass1, hit1;
  logic [gbrc_pkg::SELW-1:0]     sel1;
  logic                          hit_c;
  logic [gbrc_pkg::SELW-1:0]     sel_c;

  always_comb begin
    hit_c = 1'b0;
    sel_c = '0;
    for (int i = gbrc_pkg::NBANDS - 1; i >= 0; i--) begin
      if (wavelength_tenths >= gbrc_pkg::BAND_LO[i] &&
          wavelength_tenths <= gbrc_pkg::BAND_HI[i]) begin
        hit_c = 1'b1;
        sel_c = gbrc_pkg::SELW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
    if (adv) begin
      r1    <= rrs_in;
      pass1 <= wavelength_tenths >= gbrc_pkg::PASS_LO &&
               wavelength_tenths <= gbrc_pkg::PASS_HI;
      hit1  <= hit_c;
      sel1  <= sel_c;
    end
  end

  // stage 2
  logic                          v2;
  logic signed [gbrc_pkg::RW-1:0] r2;
  logic signed [63:0]            prod2;
  gbrc_pkg::status_t             st2;
  logic                          pow2;
  logic [gbrc_pkg::SELW-1:0]     sel2;
  logic [gbrc_pkg::RW-1:0]       m2;
  logic signed [gbrc_pkg::RW-1:0] lq2;
  gbrc_pkg::status_t             st_c;
  logic                          pow_c;
  logic [4:0]                    p_c;
  logic [gbrc_pkg::RW-1:0]       rpos;

  always_comb begin
    st_c  = gbrc_pkg::ST_CONV;
    pow_c = 1'b0;
    priority if (pass1) begin
      st_c = gbrc_pkg::ST_PASS;
    end else if (!hit1) begin
      st_c = gbrc_pkg::ST_UNSUP;
    end else if (r1 < gbrc_pkg::SW_Q[sel1]) begin
      if (r1 <= 0) begin
        st_c = gbrc_pkg::ST_INVALID;
      end else begin
        pow_c = 1'b1;
      end
    end else begin
      st_c = gbrc_pkg::ST_CONV;
    end
    rpos = r1;
    p_c  = '0;
    for (int b = 1; b <= 30; b++) begin
      if (rpos[b]) begin
        p_c = 5'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
    if (adv) begin
      r2    <= r1;
      prod2 <= 64'(r1) * 64'(gbrc_pkg::A2_Q[sel1]);
      st2   <= st_c;
      pow2  <= pow_c;
      sel2  <= sel1;
      m2    <= rpos << (5'd31 - p_c);
      lq2   <= (gbrc_pkg::RW'(signed'({1'b0, p_c})) - gbrc_pkg::RW'(gbrc_pkg::FRAC_BITS))
               <<< gbrc_pkg::LOGF;
    end
  end

  // stage 3: linear result and output mux
  logic signed [63:0] lin_c;
  logic [gbrc_pkg::RW-1:0] res_c;

  always_comb begin
    lin_c = ((prod2 + (64'sd1 <<< 29)) >>> 30) - 64'(gbrc_pkg::B2_Q[sel2]);
    res_c = '0;
    if (st2 == gbrc_pkg::ST_PASS) begin
      res_c = r2;
    end else if (st2 == gbrc_pkg::ST_CONV && !pow2) begin
      if (lin_c > 64'sd2147483647) begin
        res_c = 32'h7fff_ffff;
      end else if (lin_c < -64'sd2147483648) begin
        res_c = 32'h8000_0000;
      end else begin
        res_c = lin_c[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= v2;
    end
    if (adv) begin
      item.pow    <= pow2;
      item.status <= st2;
      item.res    <= res_c;
      sel         <= sel2;
      mant        <= m2;
      lq          <= lq2;
    end
  end

endmodule

// ----- rtl/gbrc_log2.sv -----
// log2 fraction bits: one squaring round per pipeline stage.
module gbrc_log2 (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          in_v,
  input  gbrc_pkg::item_t               in_item,
  input  logic [gbrc_pkg::SELW-1:0]     in_sel,
  input  logic [gbrc_pkg::RW-1:0]       in_m,
  input  logic signed [gbrc_pkg::RW-1:0] in_lq,
  output logic                          valid,
  output gbrc_pkg::item_t               item,
  output logic [gbrc_pkg::SELW-1:0]     sel,
  output logic signed [gbrc_pkg::RW-1:0] lq
);

  localparam int N = gbrc_pkg::LOGF;

  logic                          v  [N+1];
  gbrc_pkg::item_t               it [N+1];
  logic [gbrc_pkg::SELW-1:0]     sl [N+1];
  logic [gbrc_pkg::RW-1:0]       m  [N+1];
  logic signed [gbrc_pkg::RW-1:0] l [N+1];

  assign v[0]  = in_v;
  assign it[0] = in_item;
  assign sl[0] = in_sel;
  assign m[0]  = in_m;
  assign l[0]  = in_lq;

  for (genvar j = 0; j < N; j++) begin : g_round
    localparam int K = N - 1 - j;
    logic [63:0] sq;
    logic [32:0] t;
    assign sq = 64'(m[j]) * 64'(m[j]);
    assign t  = sq[63:31];

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j+1] <= 1'b0;
      end else if (adv) begin
        v[j+1] <= v[j];
      end
      if (adv) begin
        it[j+1] <= it[j];
        sl[j+1] <= sl[j];
        if (t[32]) begin
          m[j+1] <= t[32:1];
          l[j+1] <= l[j] + (gbrc_pkg::RW'(1) << K);
        end else begin
          m[j+1] <= t[31:0];
          l[j+1] <= l[j];
        end
      end
    end
  end

  assign valid = v[N];
  assign item  = it[N];
  assign sel   = sl[N];
  assign lq    = l[N];

endmodule

// ----- rtl/gbrc_exp2.sv -----
// Scale and offset in the log domain, exp2 product chain, final shift.
module gbrc_exp2 (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          in_v,
  input  gbrc_pkg::item_t               in_item,
  input  logic [gbrc_pkg::SELW-1:0]     in_sel,
  input  logic signed [gbrc_pkg::RW-1:0] in_lq,
  output logic                          valid,
  output gbrc_pkg::item_t               item
);

  localparam int N = gbrc_pkg::LOGF;

  // stage X1: a1 * log2(R)
  logic                          vx1;
  gbrc_pkg::item_t               itx1;
  logic [gbrc_pkg::SELW-1:0]     selx1;
  logic signed [63:0]            px1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vx1 <= 1'b0;
    end else if (adv) begin
      vx1 <= in_v;
    end
    if (adv) begin
      itx1  <= in_item;
      selx1 <= in_sel;
      px1   <= 64'(in_lq) * 64'(gbrc_pkg::A1_Q[in_sel]);
    end
  end

  // stage X2: split into exponent and fraction
  logic signed [63:0] z_c;
  logic                      v  [N+1];
  gbrc_pkg::item_t           it [N+1];
  logic signed [gbrc_pkg::NW-1:0] n [N+1];
  logic [N-1:0]              f  [N+1];
  logic [31:0]               mt [N+1];

  assign z_c = ((px1 + (64'sd1 <<< 29)) >>> 30) - 64'(gbrc_pkg::B1_Q[selx1])
               + (64'(gbrc_pkg::FRAC_BITS) <<< gbrc_pkg::LOGF);

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (adv) begin
      v[0] <= vx1;
    end
    if (adv) begin
      it[0] <= itx1;
      n[0]  <= z_c[gbrc_pkg::LOGF + gbrc_pkg::NW - 1:gbrc_pkg::LOGF];
      f[0]  <= z_c[N-1:0];
      mt[0] <= 32'd1 << 30;
    end
  end

  for (genvar j = 0; j < N; j++) begin : g_fac
    localparam logic [31:0] TK = gbrc_pkg::tpow(j + 1);
    logic [63:0] pr;
    assign pr = 64'(mt[j]) * 64'(TK);

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j+1] <= 1'b0;
      end else if (adv) begin
        v[j+1] <= v[j];
      end
      if (adv) begin
        it[j+1] <= it[j];
        n[j+1]  <= n[j];
        f[j+1]  <= f[j];
        mt[j+1] <= f[j][N-1-j] ? pr[61:30] : mt[j];
      end
    end
  end

  // final stage: M * 2^(n-30), rounded right shift, saturating or flushing to zero
  logic [32:0] sh_c;
  logic [4:0]  s_c;
  logic [31:0] pres_c;
  gbrc_pkg::item_t out_c;

  always_comb begin
    s_c    = 5'(gbrc_pkg::NW'(30) - n[N]);
    sh_c   = (33'(mt[N]) + (33'd1 << (s_c - 5'd1))) >> s_c;
    pres_c = '0;
    if (n[N] > 30) begin
      pres_c = 32'h7fff_ffff;
    end else if (n[N] == 30) begin
      pres_c = mt[N][31] ? 32'h7fff_ffff : mt[N];
    end else if (n[N] < -1) begin
      pres_c = '0;
    end else begin
      pres_c = sh_c[31:0];
    end
    out_c = it[N];
    if (it[N].pow) begin
      out_c.res = pres_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= v[N];
    end
    if (adv) begin
      item <= out_c;
    end
  end

endmodule

// ----- rtl/green_band_reflectance_convert.sv -----
// Top level of the green-band reflectance converter.
// Usage:
//  - Input channel: in_valid / in_stall carry rrs_in (signed, LSB 2^-28 sr^-1)
//    and wavelength_tenths. A transaction completes on a clock edge with
//    in_valid high and in_stall low.
//  - Output channel: out_valid / out_stall carry rrs_out and status
//    (0 pass, 1 converted, 2 unsupported band, 3 non-positive in power law).
//  - One result per input transaction, in order.
//  - Depth: 54 register stages (3 front stages, 24 log2 squaring stages,
//    2 log-domain stages, 24 exp2 product stages, 1 shift stage that is
//    also the output register).
//  - Throughput: one transaction per cycle unless the output is held; each
//    squaring and each exp2 multiply owns a stage, so depth sets latency.
//  - Receiver stall: when out_valid is high and out_stall is high the whole
//    pipe holds; in_stall follows so nothing is dropped or repeated.
//  - Reset (rst, synchronous): clears every stage valid bit; the pipe comes
//    up empty and ready on the next cycle.
module green_band_reflectance_convert (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [gbrc_pkg::RW-1:0] rrs_in,
  input  logic [gbrc_pkg::WW-1:0]       wavelength_tenths,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [gbrc_pkg::RW-1:0] rrs_out,
  output logic [1:0]                    status
);

  logic adv;

  // Front outputs
  logic                          f_v;
  gbrc_pkg::item_t               f_item;
  logic [gbrc_pkg::SELW-1:0]     f_sel;
  logic [gbrc_pkg::RW-1:0]       f_m;
  logic signed [gbrc_pkg::RW-1:0] f_lq;

  // log2 outputs
  logic                          l_v;
  gbrc_pkg::item_t               l_item;
  logic [gbrc_pkg::SELW-1:0]     l_sel;
  logic signed [gbrc_pkg::RW-1:0] l_lq;

  gbrc_pkg::item_t               o_item;

  // Pipe moves whenever the output register is empty or being drained.
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  gbrc_front u_front (
    .clk               (clk),
    .rst               (rst),
    .adv               (adv),
    .in_valid          (in_valid),
    .rrs_in            (rrs_in),
    .wavelength_tenths (wavelength_tenths),
    .valid             (f_v),
    .item              (f_item),
    .sel               (f_sel),
    .mant              (f_m),
    .lq                (f_lq)
  );

  gbrc_log2 u_log2 (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_v    (f_v),
    .in_item (f_item),
    .in_sel  (f_sel),
    .in_m    (f_m),
    .in_lq   (f_lq),
    .valid   (l_v),
    .item    (l_item),
    .sel     (l_sel),
    .lq      (l_lq)
  );

  gbrc_exp2 u_exp2 (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_v    (l_v),
    .in_item (l_item),
    .in_sel  (l_sel),
    .in_lq   (l_lq),
    .valid   (out_valid),
    .item    (o_item)
  );

  assign rrs_out = o_item.res;
  assign status  = o_item.status;

endmodule

// ----- rtl/gbrc_checker.sv -----
// Port-level checks for the converter, bound to the top level.
module gbrc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [gbrc_pkg::RW-1:0]       rrs_out,
  input logic [1:0]                    status
);

  // Pipe comes up empty after reset.
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high right after reset");

  // Input back-pressure only from a held result.
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("in_stall not tied to output hold");

  // Held result stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(rrs_out) && $stable(status))
    else $error("held result changed");

  // Error statuses carry a zero result.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == gbrc_pkg::ST_UNSUP || status == gbrc_pkg::ST_INVALID)
    |-> rrs_out == '0)
    else $error("error status with nonzero result");

endmodule

bind green_band_reflectance_convert gbrc_checker u_gbrc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .rrs_out   (rrs_out),
  .status    (status)
);
